// ===== rtl/core/aarm_pkg.sv =====
`default_nettype none
package aarm_pkg;

  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int TRIG_ITER_DEF     = 16;

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 31;
  localparam int LAT_NORM  = 2 + SQ_STEPS + DIV_STEPS + 1;
  localparam int LAT_MAT   = 4;
  localparam int LAT_TRIG_FIXED = 5;

  localparam logic [24:0] DEG_QUARTER = 25'd5898240;
  localparam logic [24:0] DEG_HALF    = 25'd11796480;
  localparam logic [24:0] DEG_THREEQ  = 25'd17694720;
  localparam logic [24:0] DEG_FULL    = 25'd23592960;

  localparam logic [15:0] DIV360_MUL = 16'd46604;
  localparam logic [8:0]  DEG_WRAP   = 9'd360;
  localparam logic [8:0]  WRAP_OFS   = 9'd8;

  localparam logic [30:0] RAD_PER_DEG = 31'd1199381129;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage
`default_nettype wire

// ===== rtl/core/axis_angle_rotation_matrix_unit.sv =====
`default_nettype none
// Axis-angle rotation matrix: each input word carries an angle (degrees, 16 fraction
// bits, any value, wrapped modulo 360) and an integer axis of any scale; the unit gives
// the nine entries of the 3x3 rotation matrix row by row, signed with OUT_FRAC_BITS
// fraction bits, saturated to +-1. A zero axis produces no output word. The pipeline
// takes one word per clock while in_tready is high; latency from accept to out_tvalid
// is set by the axis normalization path (31-stage square root, 31-stage divider).
// A two-entry output buffer keeps in_tready registered while out_tready is low.
module axis_angle_rotation_matrix_unit #(
  parameter int OUT_FRAC_BITS   = aarm_pkg::OUT_FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = aarm_pkg::TRIG_ITER_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [79:0]  in_tdata,   // angle_deg[31:0], axis_x, axis_y, axis_z
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [143:0] out_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int LAT_TRIG = aarm_pkg::LAT_TRIG_FIXED + TRIG_ITERATIONS;
  localparam int DLY      = aarm_pkg::LAT_NORM - LAT_TRIG;

  logic spare_v_r, out_v_r;
  logic en;
  assign en        = !spare_v_r;
  assign in_tready = en;

  logic signed [33:0] sn, cs;
  logic               nv;
  logic signed [31:0] ux, uy, uz;

  aarm_trig #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig (
    .clk   (clk),
    .en    (en),
    .angle (in_tdata[31:0]),
    .sn    (sn),
    .cs    (cs)
  );

  aarm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_x      (in_tdata[47:32]),
    .in_y      (in_tdata[63:48]),
    .in_z      (in_tdata[79:64]),
    .out_valid (nv),
    .out_ux    (ux),
    .out_uy    (uy),
    .out_uz    (uz)
  );

  // align sine/cosine with the normalized axis
  logic [67:0] dly_r [DLY];
  for (genvar k = 0; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        if (k == 0) begin
          dly_r[k] <= {sn, cs};
        end else begin
          dly_r[k] <= dly_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  logic               mv;
  logic [8:0][15:0]   mdat;
  logic signed [33:0] sn_d, cs_d;
  assign sn_d = dly_r[DLY-1][67:34];
  assign cs_d = dly_r[DLY-1][33:0];

  aarm_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nv),
    .ux        (ux),
    .uy        (uy),
    .uz        (uz),
    .sn        (sn_d),
    .cs        (cs_d),
    .out_valid (mv),
    .out_m     (mdat)
  );

  // output register plus spare word
  logic [143:0] out_r, spare_r;
  logic         take;
  assign take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (spare_v_r) begin
      if (take) begin
        out_r     <= spare_r;
        spare_v_r <= 1'b0;
      end
    end else if (mv) begin
      if (!out_v_r || take) begin
        out_r   <= mdat;
        out_v_r <= 1'b1;
      end else begin
        spare_r   <= mdat;
        spare_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/aarm_trig.sv =====
`default_nettype none
module aarm_trig #(
  parameter int TRIG_ITERATIONS = aarm_pkg::TRIG_ITER_DEF
) (
  input  wire                clk,
  input  wire                en,
  input  wire  [31:0]        angle,
  output logic signed [33:0] sn,
  output logic signed [33:0] cs
);

  localparam int NIT = TRIG_ITERATIONS;

  // reduce modulo 360 degrees
  logic [15:0] h1_r, frac1_r, frac2_r;
  logic [7:0]  q1_r;
  logic [8:0]  d2_r;
  logic [31:0] prod1;
  logic [15:0] r2;
  logic [8:0]  r2s, d2_nxt;

  assign prod1 = {~angle[31], angle[30:16]} * aarm_pkg::DIV360_MUL;
  assign r2    = h1_r - 16'(q1_r * aarm_pkg::DEG_WRAP);
  assign r2s   = r2[8:0];
  assign d2_nxt = (r2s >= aarm_pkg::WRAP_OFS) ? r2s - aarm_pkg::WRAP_OFS
                                              : r2s + (aarm_pkg::DEG_WRAP - aarm_pkg::WRAP_OFS);

  // fold to first quadrant
  logic [24:0] a3;
  logic [22:0] t3_nxt, t3_r;
  logic        ns3_nxt, nc3_nxt, ns3_r, nc3_r;

  assign a3 = {d2_r, frac2_r};
  always_comb begin
    if (a3 <= aarm_pkg::DEG_QUARTER) begin
      t3_nxt = a3[22:0]; ns3_nxt = 1'b0; nc3_nxt = 1'b0;
    end else if (a3 <= aarm_pkg::DEG_HALF) begin
      t3_nxt = 23'(aarm_pkg::DEG_HALF - a3); ns3_nxt = 1'b0; nc3_nxt = 1'b1;
    end else if (a3 <= aarm_pkg::DEG_THREEQ) begin
      t3_nxt = 23'(a3 - aarm_pkg::DEG_HALF); ns3_nxt = 1'b1; nc3_nxt = 1'b1;
    end else begin
      t3_nxt = 23'(aarm_pkg::DEG_FULL - a3); ns3_nxt = 1'b1; nc3_nxt = 1'b0;
    end
  end

  // degrees to radians, Q30
  logic [54:0] rad4;
  logic signed [33:0] cz4_r;
  logic ns4_r, nc4_r;

  assign rad4 = 55'(t3_r) * 55'(aarm_pkg::RAD_PER_DEG) + (55'd1 << 21);

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r    <= prod1[31:24];
      h1_r    <= {~angle[31], angle[30:16]};
      frac1_r <= angle[15:0];
      d2_r    <= d2_nxt;
      frac2_r <= frac1_r;
      t3_r    <= t3_nxt;
      ns3_r   <= ns3_nxt;
      nc3_r   <= nc3_nxt;
      cz4_r   <= {3'b000, rad4[52:22]};
      ns4_r   <= ns3_r;
      nc4_r   <= nc3_r;
    end
  end

  // CORDIC rotation, one iteration per stage
  logic signed [33:0] cx_r [NIT];
  logic signed [33:0] cy_r [NIT];
  logic signed [33:0] cz_r [NIT];
  logic               ns_r [NIT];
  logic               nc_r [NIT];

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    logic signed [33:0] px, py, pz, dx, dy, at;
    logic               ps, pc;
    if (i == 0) begin : g_first
      assign px = aarm_pkg::CORDIC_GAIN;
      assign py = '0;
      assign pz = cz4_r;
      assign ps = ns4_r;
      assign pc = nc4_r;
    end else begin : g_next
      assign px = cx_r[i-1];
      assign py = cy_r[i-1];
      assign pz = cz_r[i-1];
      assign ps = ns_r[i-1];
      assign pc = nc_r[i-1];
    end
    assign dx = py >>> i;
    assign dy = px >>> i;
    assign at = {2'b00, aarm_pkg::ATAN_Q30[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!pz[33]) begin
          cx_r[i] <= px - dx;
          cy_r[i] <= py + dy;
          cz_r[i] <= pz - at;
        end else begin
          cx_r[i] <= px + dx;
          cy_r[i] <= py - dy;
          cz_r[i] <= pz + at;
        end
        ns_r[i] <= ps;
        nc_r[i] <= pc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= ns_r[NIT-1] ? -cy_r[NIT-1] : cy_r[NIT-1];
      cs <= nc_r[NIT-1] ? -cx_r[NIT-1] : cx_r[NIT-1];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/aarm_norm.sv =====
`default_nettype none
module aarm_norm (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  wire  [15:0]        in_x,
  input  wire  [15:0]        in_y,
  input  wire  [15:0]        in_z,
  output logic               out_valid,
  output logic signed [31:0] out_ux,
  output logic signed [31:0] out_uy,
  output logic signed [31:0] out_uz
);

  localparam int SQN = aarm_pkg::SQ_STEPS;
  localparam int DVN = aarm_pkg::DIV_STEPS;

  typedef struct packed {
    logic             valid;
    logic [31:0]      ssum;
    logic [31:0]      rem;
    logic [30:0]      root;
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
  } sq_t;

  typedef struct packed {
    logic             valid;
    logic [30:0]      root;
    logic [2:0][30:0] rem;
    logic [2:0][30:0] q;
    logic [2:0]       neg;
  } dv_t;

  // squares and sum
  logic             v1_r, v2_r;
  logic [2:0][30:0] sq1_r;
  logic [2:0][15:0] mag1_r, mag2_r;
  logic [2:0]       neg1_r, neg2_r;
  logic [31:0]      ssum2_r, ssum1;
  logic [2:0][15:0] vin;
  logic signed [31:0] p0, p1, p2;

  assign vin = {in_z, in_y, in_x};
  assign p0 = $signed(in_x) * $signed(in_x);
  assign p1 = $signed(in_y) * $signed(in_y);
  assign p2 = $signed(in_z) * $signed(in_z);
  assign ssum1 = 32'(sq1_r[0]) + 32'(sq1_r[1]) + 32'(sq1_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r && (ssum1 != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r[0] <= p0[30:0];
      sq1_r[1] <= p1[30:0];
      sq1_r[2] <= p2[30:0];
      for (int k = 0; k < 3; k++) begin
        mag1_r[k] <= vin[k][15] ? 16'(-vin[k]) : vin[k];
        neg1_r[k] <= vin[k][15];
      end
      ssum2_r <= ssum1;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
    end
  end

  // square root of ssum << 30, one root bit per stage
  sq_t sq_r [SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam int J = SQN - 1 - k;
    sq_t         prev, nxt;
    logic [61:0] nfull;
    logic [33:0] trial, test;
    if (k == 0) begin : g_first
      assign prev = '{valid: v2_r, ssum: ssum2_r, rem: '0, root: '0,
                      mag: mag2_r, neg: neg2_r};
    end else begin : g_next
      assign prev = sq_r[k-1];
    end
    assign nfull = {prev.ssum, 30'd0};
    assign trial = {prev.rem, nfull[2*J+1 -: 2]};
    assign test  = {1'b0, prev.root, 2'b01};
    always_comb begin
      nxt = prev;
      if (trial >= test) begin
        nxt.rem  = 32'(trial - test);
        nxt.root = {prev.root[29:0], 1'b1};
      end else begin
        nxt.rem  = trial[31:0];
        nxt.root = {prev.root[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k].valid <= 1'b0;
      end else if (en) begin
        sq_r[k] <= nxt;
      end
    end
  end

  // (|v| << 45 + R/2) / R, one quotient bit per stage
  dv_t         dv_r [DVN];
  logic [30:0] sroot;
  sq_t         sq_last;

  assign sq_last = sq_r[SQN-1];
  assign sroot   = sq_last.root;

  for (genvar s = 0; s < DVN; s++) begin : g_div
    localparam int B = DVN - 1 - s;
    dv_t         prev, nxt;
    logic [30:0] low;
    if (s == 0) begin : g_first
      always_comb begin
        prev.valid = sq_last.valid;
        prev.root  = sroot;
        prev.neg   = sq_last.neg;
        for (int c = 0; c < 3; c++) begin
          prev.rem[c] = {1'b0, sq_last.mag[c], 14'd0};
          prev.q[c]   = '0;
        end
      end
    end else begin : g_next
      assign prev = dv_r[s-1];
    end
    assign low = {1'b0, prev.root[30:1]};
    always_comb begin
      logic [31:0] r2;
      nxt = prev;
      for (int c = 0; c < 3; c++) begin
        r2 = {prev.rem[c], low[B]};
        if (r2 >= {1'b0, prev.root}) begin
          nxt.rem[c] = 31'(r2 - {1'b0, prev.root});
          nxt.q[c]   = {prev.q[c][29:0], 1'b1};
        end else begin
          nxt.rem[c] = r2[30:0];
          nxt.q[c]   = {prev.q[c][29:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s].valid <= 1'b0;
      end else if (en) begin
        dv_r[s] <= nxt;
      end
    end
  end

  dv_t dv_last;
  logic signed [31:0] qx, qy, qz;

  assign dv_last = dv_r[DVN-1];
  assign qx = {1'b0, dv_last.q[0]};
  assign qy = {1'b0, dv_last.q[1]};
  assign qz = {1'b0, dv_last.q[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ux <= dv_last.neg[0] ? -qx : qx;
      out_uy <= dv_last.neg[1] ? -qy : qy;
      out_uz <= dv_last.neg[2] ? -qz : qz;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/aarm_matrix.sv =====
`default_nettype none
module aarm_matrix #(
  parameter int OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  wire signed [31:0]  ux,
  input  wire signed [31:0]  uy,
  input  wire signed [31:0]  uz,
  input  wire signed [33:0]  sn,
  input  wire signed [33:0]  cs,
  output logic               out_valid,
  output logic [8:0][15:0]   out_m
);

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [35:0] RND =
    (SH > 0) ? (36'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 36'sd0;
  localparam logic signed [35:0] LIM = 36'sd1 <<< OUT_FRAC_BITS;

  function automatic logic signed [34:0] qmul(input logic signed [34:0] a,
                                              input logic signed [34:0] b);
    logic signed [69:0] p;
    p = a * b + (70'sd1 <<< 29);
    return p[64:30];
  endfunction

  logic signed [34:0] x, y, z, s, c;
  assign x = {{3{ux[31]}}, ux};
  assign y = {{3{uy[31]}}, uy};
  assign z = {{3{uz[31]}}, uz};
  assign s = {sn[33], sn};
  assign c = {cs[33], cs};

  logic v1_r, v2_r, v3_r;
  logic signed [34:0] xx_r, yy_r, zz_r, xy_r, yz_r, zx_r, xs_r, ys_r, zs_r, omc_r, c1_r;
  logic signed [34:0] pxx_r, pyy_r, pzz_r, pxy_r, pyz_r, pzx_r, xs2_r, ys2_r, zs2_r, c2_r;
  logic signed [34:0] m3_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r  <= qmul(x, x);
      yy_r  <= qmul(y, y);
      zz_r  <= qmul(z, z);
      xy_r  <= qmul(x, y);
      yz_r  <= qmul(y, z);
      zx_r  <= qmul(z, x);
      xs_r  <= qmul(x, s);
      ys_r  <= qmul(y, s);
      zs_r  <= qmul(z, s);
      omc_r <= aarm_pkg::Q30_ONE - c;
      c1_r  <= c;

      pxx_r <= qmul(omc_r, xx_r);
      pyy_r <= qmul(omc_r, yy_r);
      pzz_r <= qmul(omc_r, zz_r);
      pxy_r <= qmul(omc_r, xy_r);
      pyz_r <= qmul(omc_r, yz_r);
      pzx_r <= qmul(omc_r, zx_r);
      xs2_r <= xs_r;
      ys2_r <= ys_r;
      zs2_r <= zs_r;
      c2_r  <= c1_r;

      m3_r[0] <= pxx_r + c2_r;
      m3_r[1] <= pxy_r - zs2_r;
      m3_r[2] <= pzx_r + ys2_r;
      m3_r[3] <= pxy_r + zs2_r;
      m3_r[4] <= pyy_r + c2_r;
      m3_r[5] <= pyz_r - xs2_r;
      m3_r[6] <= pzx_r - ys2_r;
      m3_r[7] <= pyz_r + xs2_r;
      m3_r[8] <= pzz_r + c2_r;
    end
  end

  // round half up, saturate, keep low 16 bits
  for (genvar k = 0; k < 9; k++) begin : g_out
    logic signed [35:0] e, sat;
    assign e = ($signed({m3_r[k][34], m3_r[k]}) + RND) >>> SH;
    always_comb begin
      if (e > LIM) begin
        sat = LIM;
      end else if (e < -LIM) begin
        sat = -LIM;
      end else begin
        sat = e;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        out_m[k] <= sat[15:0];
      end
    end
  end

endmodule
`default_nettype wire
